[hdl/mtsc_pkg.sv]
// mtsc_pkg: types, constants and helper functions for the matrix text shape checker
// depends on nothing; imported by mtsc_step, matrix_text_shape_checker and the testbench
`timescale 1ns / 1ps

package mtsc_pkg;

    // counter width and the width of the reported counter fields
    localparam int COUNT_BITS = 16;
    localparam int OUT_BITS   = 16;

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [OUT_BITS-1:0]   out_count_t;
    typedef logic [7:0]            byte_t;

    localparam count_t COUNT_ZERO = '0;
    localparam count_t COUNT_ONE  = {{(COUNT_BITS-1){1'b0}}, 1'b1};
    localparam count_t COUNT_MAX  = '1;

    // byte codes the checker looks at
    localparam byte_t CH_TAB   = 8'h09;
    localparam byte_t CH_NL    = 8'h0A;
    localparam byte_t CH_CR    = 8'h0D;
    localparam byte_t CH_SP    = 8'h20;
    localparam byte_t CH_DASH  = 8'h2D;
    localparam byte_t CH_DOT   = 8'h2E;
    localparam byte_t CH_ZERO  = 8'h30;
    localparam byte_t CH_NINE  = 8'h39;

    // reported status codes
    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_BAD_BYTE     = 2'd1,
        ST_COL_MISMATCH = 2'd2,
        ST_EMPTY        = 2'd3
    } status_t;

    // scan state carried from one byte to the next
    typedef struct packed {
        logic    prev_nl;
        logic    prev_sp;
        logic    first_row_done;
        logic    digit_seen;
        count_t  rows;
        count_t  cols;
        count_t  row_cols;
        count_t  lines;
        status_t err;
        logic    end_seen;
    } scan_state_t;

    localparam scan_state_t SCAN_RESET = '{
        prev_nl:        1'b0,
        prev_sp:        1'b0,
        first_row_done: 1'b0,
        digit_seen:     1'b0,
        rows:           COUNT_ZERO,
        cols:           COUNT_ONE,
        row_cols:       COUNT_ONE,
        lines:          COUNT_ZERO,
        err:            ST_OK,
        end_seen:       1'b0
    };

    // saturating increment
    function automatic count_t sat_inc(count_t v);
        return (v == COUNT_MAX) ? v : v + COUNT_ONE;
    endfunction

    // decrement that stops at zero
    function automatic count_t sat_dec(count_t v);
        return (v == COUNT_ZERO) ? v : v - COUNT_ONE;
    endfunction

    // low bits of a counter, zero extended when the counter is narrower
    function automatic out_count_t to_out(count_t v);
        logic [COUNT_BITS+OUT_BITS-1:0] w;
        w = {{OUT_BITS{1'b0}}, v};
        return w[OUT_BITS-1:0];
    endfunction

endpackage

[hdl/mtsc_step.sv]
// mtsc_step: next scan state for one byte or end marker
// depends on mtsc_pkg
`timescale 1ns / 1ps

module mtsc_step (
    input  mtsc_pkg::scan_state_t cur,
    input  mtsc_pkg::byte_t       char_code,
    input  logic                  end_of_text,
    output mtsc_pkg::scan_state_t nxt
);
    import mtsc_pkg::*;

    byte_t       c;
    logic        take;
    logic        is_nl;
    logic        is_sp;
    logic        is_digit;
    logic        is_ws;
    logic        is_ok;
    logic        digit_now;
    logic        close_row;
    logic        close_later;
    count_t      row_cols_fix;
    scan_state_t tb;

    // byte to scan: an end marker scans a newline unless one came last
    always_comb begin
        c    = end_of_text ? CH_NL : char_code;
        take = !end_of_text || !cur.prev_nl;
    end

    // byte classes
    always_comb begin
        is_nl    = (c == CH_NL);
        is_sp    = (c == CH_SP);
        is_digit = c inside {[CH_ZERO:CH_NINE]};
        is_ws    = is_sp || (c inside {[CH_TAB:CH_CR]});
        is_ok    = is_digit || is_ws || (c == CH_DOT) || (c == CH_DASH);
    end

    // scan one byte
    always_comb begin
        tb           = cur;
        digit_now    = cur.digit_seen || is_digit;
        close_row    = is_nl && !cur.prev_nl && digit_now;
        close_later  = close_row && cur.first_row_done;
        row_cols_fix = cur.prev_sp ? sat_dec(cur.row_cols) : cur.row_cols;

        if (is_nl) begin
            tb.lines = sat_inc(cur.lines);
        end

        if (!is_ok) begin
            tb.err = ST_BAD_BYTE;
        end else begin
            tb.digit_seen = digit_now;
            tb.prev_nl    = is_nl;
            tb.prev_sp    = is_sp;

            // newline closes a row that held a digit
            if (close_row) begin
                tb.rows           = sat_inc(cur.rows);
                tb.first_row_done = 1'b1;
                tb.digit_seen     = 1'b0;
                if (!cur.first_row_done && cur.prev_sp) begin
                    tb.cols = sat_dec(cur.cols);
                end
            end

            // first space of a run after a digit opens a column
            if (is_sp && !cur.prev_sp && digit_now) begin
                if (!cur.first_row_done) begin
                    tb.cols = sat_inc(cur.cols);
                end else begin
                    tb.row_cols = sat_inc(cur.row_cols);
                end
            end

            // later row must match the first row's column count
            if (close_later) begin
                if (row_cols_fix != cur.cols) begin
                    tb.err      = ST_COL_MISMATCH;
                    tb.row_cols = row_cols_fix;
                end else begin
                    tb.row_cols = COUNT_ONE;
                end
            end
        end
    end

    // end handling and sticky hold
    always_comb begin
        nxt = cur;
        if (cur.err == ST_OK && !cur.end_seen) begin
            nxt = take ? tb : cur;
            if (end_of_text) begin
                if (nxt.err == ST_OK && (nxt.rows == COUNT_ZERO || nxt.cols == COUNT_ZERO)) begin
                    nxt.err = ST_EMPTY;
                end
                nxt.end_seen = 1'b1;
            end
        end
    end

endmodule

[hdl/matrix_text_shape_checker.sv]
// matrix_text_shape_checker: top level with input register, scan state and result register
// depends on mtsc_pkg and mtsc_step
// a byte waits in the input register until its result is loaded into the result register
// throughput: one byte per cycle unless stalled; scan state steps from the input register
// backpressure on the result side stalls the input register, which stalls the input channel
// reset (aresetn low, synchronous) empties both registers and returns the scan state to its start
`timescale 1ns / 1ps

module matrix_text_shape_checker (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  mtsc_pkg::byte_t        s_char_code,
    input  logic                   s_end_of_text,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [1:0]             m_status,
    output mtsc_pkg::out_count_t   m_row_total,
    output mtsc_pkg::out_count_t   m_column_total,
    output mtsc_pkg::out_count_t   m_line_number,
    output logic                   m_finished
);
    import mtsc_pkg::*;

    logic        in_valid_reg, in_valid_next;
    byte_t       in_char_reg;
    logic        in_eot_reg;
    logic        out_valid_reg, out_valid_next;
    scan_state_t state_reg, state_next;
    status_t     status_reg;
    out_count_t  rows_reg, cols_reg, lines_reg;
    logic        finished_reg;
    logic        s_xfer;
    logic        fire;

    // handshake and stage advance
    always_comb begin
        fire    = in_valid_reg && (!out_valid_reg || m_ready);
        s_ready = !in_valid_reg || fire;
        s_xfer  = s_valid && s_ready;
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_xfer) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // scan logic for the registered byte
    mtsc_step u_step (
        .cur         (state_reg),
        .char_code   (in_char_reg),
        .end_of_text (in_eot_reg),
        .nxt         (state_next)
    );

    // control registers and scan state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= SCAN_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire) begin
                state_reg <= state_next;
            end
        end
    end

    // input payload register
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_char_reg <= s_char_code;
            in_eot_reg  <= s_end_of_text;
        end
    end

    // result payload register
    always_ff @(posedge aclk) begin
        if (fire) begin
            status_reg   <= state_next.err;
            rows_reg     <= to_out(state_next.rows);
            cols_reg     <= to_out(state_next.cols);
            lines_reg    <= to_out(state_next.lines);
            finished_reg <= state_next.end_seen || (state_next.err != ST_OK);
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_status       = status_reg;
    assign m_row_total    = rows_reg;
    assign m_column_total = cols_reg;
    assign m_line_number  = lines_reg;
    assign m_finished     = finished_reg;

    // end of text stays latched until reset
    a_end_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.end_seen |=> state_reg.end_seen)
        else $error("end flag cleared without reset");

    // a latched error never changes
    a_err_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.err != ST_OK) |=> (state_reg.err == $past(state_reg.err)))
        else $error("latched error changed");

    // newline counter never goes backward
    a_lines_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg |=> (state_reg.lines >= $past(state_reg.lines)))
        else $error("line counter decreased");

    // a held byte is not dropped while the result side stalls
    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !fire) |=> (in_valid_reg && $stable(in_char_reg)))
        else $error("stalled byte lost");

    // empty status only when nothing was counted
    a_empty_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.err == ST_EMPTY) |->
        (state_reg.rows == COUNT_ZERO || state_reg.cols == COUNT_ZERO))
        else $error("empty status with rows and columns");

endmodule

[sim/matrix_text_shape_checker_tb.sv]
// matrix_text_shape_checker_tb: self-checking bench for the matrix text shape checker
// streams one matrix text through the block, predicts every result and compares it
// depends on mtsc_pkg and matrix_text_shape_checker
`timescale 1ns / 1ps

module matrix_text_shape_checker_tb;
    import mtsc_pkg::*;

    localparam int     QUIET_LIMIT = 3000;
    localparam int     PRINT_CAP   = 50;
    localparam byte_t  CH_VT       = 8'h0B;
    localparam byte_t  CH_FF       = 8'h0C;

    // scan state kept by the bench
    typedef struct packed {
        byte_t   last_ch;
        logic    first_done;
        logic    has_digit;
        count_t  n_rows;
        count_t  n_cols;
        count_t  cur_cols;
        count_t  n_lines;
        status_t err;
        logic    ended;
    } shape_state_t;

    typedef struct packed {
        status_t    status;
        out_count_t rows;
        out_count_t cols;
        out_count_t lines;
        logic       done;
    } shape_result_t;

    typedef struct packed {
        byte_t         ch;
        logic          eot;
        logic          typed;
        shape_result_t res;
    } stim_row_t;

    // ways the text is closed at the end of the run
    typedef enum int {
        CLOSE_CLEAN,
        CLOSE_OPEN_ROW,
        CLOSE_WIDE_OPEN_ROW,
        CLOSE_WIDE_ROW,
        CLOSE_BAD_BYTE
    } closing_t;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    byte_t      s_char_code;
    logic       s_end_of_text;
    logic       m_valid;
    logic       m_ready;
    logic [1:0] m_status;
    out_count_t m_row_total;
    out_count_t m_column_total;
    out_count_t m_line_number;
    logic       m_finished;

    shape_state_t  shape;
    shape_result_t expected_shape_q[$];
    stim_row_t     dir_tab[$];
    byte_t         text_q[$];
    int            mismatch_count = 0;
    int            send_idle_pct  = 0;
    int            stall_pct      = 0;
    int            hold_req       = 0;
    int            hold_left      = 0;
    int            quiet_cycles   = 0;

    matrix_text_shape_checker u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_char_code    (s_char_code),
        .s_end_of_text  (s_end_of_text),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_row_total    (m_row_total),
        .m_column_total (m_column_total),
        .m_line_number  (m_line_number),
        .m_finished     (m_finished)
    );

    always #5 aclk = ~aclk;

    // byte classes
    function automatic logic is_num(byte_t c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic is_blank(byte_t c);
        return c == CH_SP || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic byte_allowed(byte_t c);
        return is_num(c) || is_blank(c) || c == CH_DOT || c == CH_DASH;
    endfunction

    function automatic count_t count_up(count_t v);
        return (v == COUNT_MAX) ? v : v + COUNT_ONE;
    endfunction

    function automatic count_t count_down(count_t v);
        return (v == COUNT_ZERO) ? v : v - COUNT_ONE;
    endfunction

    // one text byte through the scan
    function automatic shape_state_t take_char(shape_state_t s, byte_t c);
        logic closes_later;
        closes_later = 1'b0;
        if (c == CH_NL)
            s.n_lines = count_up(s.n_lines);
        if (!byte_allowed(c)) begin
            s.err = ST_BAD_BYTE;
            return s;
        end
        if (is_num(c))
            s.has_digit = 1'b1;
        // newline ends a row that holds a digit
        if (c == CH_NL && s.last_ch != CH_NL && s.has_digit) begin
            s.n_rows = count_up(s.n_rows);
            if (!s.first_done && s.last_ch == CH_SP)
                s.n_cols = count_down(s.n_cols);
            if (s.first_done)
                closes_later = 1'b1;
            s.first_done = 1'b1;
            s.has_digit  = 1'b0;
        end
        // first space of a run after a digit opens a column
        if (c == CH_SP && s.last_ch != CH_SP && s.has_digit) begin
            if (!s.first_done)
                s.n_cols = count_up(s.n_cols);
            else
                s.cur_cols = count_up(s.cur_cols);
        end
        if (closes_later) begin
            if (s.last_ch == CH_SP)
                s.cur_cols = count_down(s.cur_cols);
            if (s.cur_cols != s.n_cols) begin
                s.err = ST_COL_MISMATCH;
                return s;
            end
            s.cur_cols = COUNT_ONE;
        end
        s.last_ch = c;
        return s;
    endfunction

    // one input transfer, end marker included; latched state stays put
    function automatic shape_state_t shape_step(shape_state_t s, byte_t c, logic eot);
        if (s.err == ST_OK && !s.ended) begin
            if (eot) begin
                if (s.last_ch != CH_NL)
                    s = take_char(s, CH_NL);
                if (s.err == ST_OK && (s.n_rows == COUNT_ZERO || s.n_cols == COUNT_ZERO))
                    s.err = ST_EMPTY;
                s.ended = 1'b1;
            end else begin
                s = take_char(s, c);
            end
        end
        return s;
    endfunction

    function automatic shape_result_t shape_report(shape_state_t s);
        shape_result_t r;
        r.status = s.err;
        r.rows   = s.n_rows;
        r.cols   = s.n_cols;
        r.lines  = s.n_lines;
        r.done   = s.ended || s.err != ST_OK;
        return r;
    endfunction

    // true if the pending text leaves the scan without an error
    function automatic logic text_stays_ok(shape_state_t s);
        for (int i = 0; i < text_q.size(); i++)
            s = shape_step(s, text_q[i], 1'b0);
        return s.err == ST_OK;
    endfunction

    function automatic stim_row_t tab_row(byte_t c, logic eot, logic typed, status_t st,
                                          int r, int k, int l, logic f);
        stim_row_t t;
        t.ch         = c;
        t.eot        = eot;
        t.typed      = typed;
        t.res.status = st;
        t.res.rows   = out_count_t'(r);
        t.res.cols   = out_count_t'(k);
        t.res.lines  = out_count_t'(l);
        t.res.done   = f;
        return t;
    endfunction

    function automatic byte_t rand_digit();
        return CH_ZERO + byte_t'($urandom_range(0, 9));
    endfunction

    // whitespace other than space and newline
    function automatic byte_t rand_soft_blank();
        case ($urandom_range(0, 3))
            0: return CH_TAB;
            1: return CH_CR;
            2: return CH_VT;
            default: return CH_FF;
        endcase
    endfunction

    function automatic byte_t rand_blank();
        return ($urandom_range(0, 4) == 0) ? CH_SP : rand_soft_blank();
    endfunction

    function automatic byte_t rand_token_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return rand_digit();
        else if (r < 80)
            return CH_DOT;
        else if (r < 90)
            return CH_DASH;
        else
            return rand_soft_blank();
    endfunction

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // one transfer on the input channel, prediction on acceptance
    task automatic push_item(input byte_t c, input logic eot, input logic typed,
                             input shape_result_t fixed);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_char_code   <= c;
        s_end_of_text <= eot;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        shape = shape_step(shape, c, eot);
        expected_shape_q.push_back(typed ? fixed : shape_report(shape));
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++)
            push_item(text_q[i], 1'b0, 1'b0, '0);
        text_q.delete();
    endtask

    // plain row: single digits, single spaces
    task automatic canon_row(input int ntok, input logic closed);
        for (int t = 0; t < ntok; t++) begin
            if (t > 0)
                text_q.push_back(CH_SP);
            text_q.push_back(rand_digit());
        end
        if (closed)
            text_q.push_back(CH_NL);
    endtask

    // row with random tokens, separator runs, leading and trailing whitespace
    task automatic build_row(input int ntok, input logic closed);
        int    n;
        logic  has_num;
        byte_t c;
        repeat ($urandom_range(0, 2))
            text_q.push_back(rand_blank());
        for (int t = 0; t < ntok; t++) begin
            if (t > 0)
                repeat ($urandom_range(1, 3))
                    text_q.push_back(CH_SP);
            has_num = 1'b0;
            n = $urandom_range(1, 4);
            for (int k = 0; k < n; k++) begin
                c = rand_token_char();
                has_num |= is_num(c);
                text_q.push_back(c);
            end
            if (!has_num)
                text_q.push_back(rand_digit());
        end
        repeat ($urandom_range(0, 2))
            text_q.push_back(($urandom_range(0, 3) == 0) ? CH_CR : CH_SP);
        if (closed)
            text_q.push_back(CH_NL);
    endtask

    // mostly well-formed rows, some blank and digit-free lines, odd widths kept only if legal
    task automatic random_text(input int n_items);
        int   sent;
        int   tries;
        int   r;
        logic ok_line;
        sent = 0;
        while (sent < n_items) begin
            ok_line = 1'b0;
            tries   = 0;
            while (!ok_line && tries < 8) begin
                text_q.delete();
                r = $urandom_range(0, 99);
                if (r < 75) begin
                    build_row(int'(shape.n_cols), 1'b1);
                end else if (r < 85) begin
                    repeat ($urandom_range(0, 3))
                        text_q.push_back(rand_blank());
                    text_q.push_back(CH_NL);
                end else if (r < 92) begin
                    repeat ($urandom_range(1, 5))
                        case ($urandom_range(0, 3))
                            0: text_q.push_back(CH_DOT);
                            1: text_q.push_back(CH_DASH);
                            2: text_q.push_back(CH_SP);
                            default: text_q.push_back(CH_TAB);
                        endcase
                    text_q.push_back(CH_NL);
                end else begin
                    build_row($urandom_range(1, int'(shape.n_cols) + 2), 1'b1);
                end
                ok_line = text_stays_ok(shape);
                tries++;
            end
            if (!ok_line) begin
                text_q.delete();
                canon_row(int'(shape.n_cols), 1'b1);
            end
            sent += text_q.size();
            send_text();
        end
    endtask

    // sender stops until every predicted result has come back
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_shape_q.size() != 0)
            @(posedge aclk);
    endtask

    // result channel ready, with random stalls and requested hold-offs
    always @(negedge aclk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // compare each result transfer with the oldest prediction
    always @(posedge aclk) begin : result_check
        shape_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_shape_q.size() == 0) begin
                flag_mismatch("result transfer with no prediction pending");
            end else begin
                want = expected_shape_q.pop_front();
                if (m_status !== want.status)
                    flag_mismatch($sformatf("status got %0d want %0d", m_status, want.status));
                if (m_row_total !== want.rows)
                    flag_mismatch($sformatf("row_total got %0d want %0d",
                                            m_row_total, want.rows));
                if (m_column_total !== want.cols)
                    flag_mismatch($sformatf("column_total got %0d want %0d",
                                            m_column_total, want.cols));
                if (m_line_number !== want.lines)
                    flag_mismatch($sformatf("line_number got %0d want %0d",
                                            m_line_number, want.lines));
                if (m_finished !== want.done)
                    flag_mismatch($sformatf("finished got %0b want %0b",
                                            m_finished, want.done));
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        closing_t how;
        byte_t    bad;

        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_char_code   = '0;
        s_end_of_text = 1'b0;
        m_ready       = 1'b0;

        shape            = '0;
        shape.last_ch    = CH_ZERO;
        shape.n_cols     = COUNT_ONE;
        shape.cur_cols   = COUNT_ONE;
        shape.err        = ST_OK;

        // directed text: leading blanks, sign, point, digit extremes, space runs,
        // trailing spaces on first and later rows, blank line with carriage return
        dir_tab.push_back(tab_row(CH_SP,   1'b0, 1'b1, ST_OK, 0, 1, 0, 1'b0));
        dir_tab.push_back(tab_row(CH_TAB,  1'b0, 1'b0, ST_OK, 0, 0, 0, 1'b0));
        dir_tab.push_back(tab_row(CH_DASH, 1'b0, 1'b0, ST_OK, 0, 0, 0, 1'b0));
        dir_tab.push_back(tab_row(CH_ZERO, 1'b0, 1'b0, ST_OK, 0, 0, 0, 1'b0));
        dir_tab.push_back(tab_row(CH_DOT,  1'b0, 1'b0, ST_OK, 0, 0, 0, 1'b0));
        dir_tab.push_back(tab_row(CH_NINE, 1'b0, 1'b0, ST_OK, 0, 0, 0, 1'b0));
        dir_tab.push_back(tab_row(CH_SP,   1'b0, 1'b0, ST_OK, 0, 0, 0, 1'b0));
        dir_tab.push_back(tab_row(CH_SP,   1'b0, 1'b0, ST_OK, 0, 0, 0, 1'b0));
        dir_tab.push_back(tab_row(CH_VT,   1'b0, 1'b0, ST_OK, 0, 0, 0, 1'b0));
        dir_tab.push_back(tab_row(CH_ZERO + 8'd5, 1'b0, 1'b0, ST_OK, 0, 0, 0, 1'b0));
        dir_tab.push_back(tab_row(CH_SP,   1'b0, 1'b0, ST_OK, 0, 0, 0, 1'b0));
        dir_tab.push_back(tab_row(CH_NL,   1'b0, 1'b1, ST_OK, 1, 2, 1, 1'b0));
        dir_tab.push_back(tab_row(CH_CR,   1'b0, 1'b0, ST_OK, 0, 0, 0, 1'b0));
        dir_tab.push_back(tab_row(CH_NL,   1'b0, 1'b1, ST_OK, 1, 2, 2, 1'b0));
        dir_tab.push_back(tab_row(CH_FF,   1'b0, 1'b0, ST_OK, 0, 0, 0, 1'b0));
        dir_tab.push_back(tab_row(CH_ZERO + 8'd7, 1'b0, 1'b0, ST_OK, 0, 0, 0, 1'b0));
        dir_tab.push_back(tab_row(CH_SP,   1'b0, 1'b0, ST_OK, 0, 0, 0, 1'b0));
        dir_tab.push_back(tab_row(CH_ZERO + 8'd8, 1'b0, 1'b0, ST_OK, 0, 0, 0, 1'b0));
        dir_tab.push_back(tab_row(CH_SP,   1'b0, 1'b0, ST_OK, 0, 0, 0, 1'b0));
        dir_tab.push_back(tab_row(CH_SP,   1'b0, 1'b0, ST_OK, 0, 0, 0, 1'b0));
        dir_tab.push_back(tab_row(CH_NL,   1'b0, 1'b1, ST_OK, 2, 2, 3, 1'b0));

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (dir_tab[i])
            push_item(dir_tab[i].ch, dir_tab[i].eot, dir_tab[i].typed, dir_tab[i].res);

        // random text, no idling, then sender gaps
        random_text(450);
        send_idle_pct = 73;
        random_text(450);
        send_idle_pct = 0;
        wait_drained();

        // receiver stalls
        stall_pct = 73;
        random_text(450);

        // long receiver hold-off while the sender keeps offering
        stall_pct = 0;
        hold_req  = 60;
        random_text(120);

        // both sides idle now and then
        send_idle_pct = 23;
        stall_pct     = 23;
        random_text(450);
        wait_drained();

        // close the text in one of several ways
        how = closing_t'($urandom_range(0, 4));
        case (how)
            CLOSE_OPEN_ROW:      canon_row(int'(shape.n_cols), 1'b0);
            CLOSE_WIDE_OPEN_ROW: canon_row(int'(shape.n_cols) + 1, 1'b0);
            CLOSE_WIDE_ROW:      canon_row(int'(shape.n_cols) + 1, 1'b1);
            default: ;
        endcase
        send_text();
        if (how == CLOSE_BAD_BYTE) begin
            bad = byte_t'($urandom_range(0, 255));
            while (byte_allowed(bad))
                bad = byte_t'($urandom_range(0, 255));
            push_item(bad, 1'b0, 1'b0, '0);
        end else if (how != CLOSE_WIDE_ROW) begin
            push_item(byte_t'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
        end

        // everything after is latched: byte extremes, repeated end markers, random bytes
        push_item(8'hFF, 1'b0, 1'b0, '0);
        push_item(8'h00, 1'b1, 1'b0, '0);
        repeat (30)
            push_item(byte_t'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0), 1'b0, '0);

        send_idle_pct = 0;
        stall_pct     = 0;
        wait_drained();
        repeat (10) @(posedge aclk);

        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[filelist.f]
hdl/mtsc_pkg.sv
hdl/mtsc_step.sv
hdl/matrix_text_shape_checker.sv
sim/matrix_text_shape_checker_tb.sv
